### rtl/core/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the running median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int         WINDOW_SIZE_BITS  = 7;
   localparam logic [6:0] WINDOW_SIZE_RESET = 7'd3;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic load;
      logic clear;
      logic full;
      logic restart;
   } swm_cmd_type;

   // handed between neighbouring cells
   typedef struct packed {
      logic valid;
      logic up;
      logic down;
   } swm_link_type;

endpackage

### rtl/core/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted window: value, age tag and valid bit. Moves up or
// down by one place per transaction, or takes the new sample.
// ----------------------------------------------------------------------------
module swm_cell
   import swm_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int AGE_BITS    = 6,
   parameter int INDEX       = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swm_cmd_type                   cmd,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-1:0] oldest_value,
   input  logic [AGE_BITS-1:0]           age_last,
   input  logic [AGE_BITS-1:0]           lo_index,
   input  logic [AGE_BITS-1:0]           hi_index,
   input  swm_link_type                  prev_link,
   input  logic signed [SAMPLE_BITS-1:0] prev_value,
   input  logic [AGE_BITS-1:0]           prev_age,
   input  swm_link_type                  next_link,
   input  logic signed [SAMPLE_BITS-1:0] next_value,
   input  logic [AGE_BITS-1:0]           next_age,
   output swm_link_type                  link,
   output logic signed [SAMPLE_BITS-1:0] value,
   output logic [AGE_BITS-1:0]           age,
   output logic signed [SAMPLE_BITS-1:0] oldest_tap,
   output logic signed [SAMPLE_BITS-1:0] lo_tap,
   output logic signed [SAMPLE_BITS-1:0] hi_tap
);

   logic signed [SAMPLE_BITS-1:0] value_ff, value_in;
   logic [AGE_BITS-1:0]           age_ff, age_in;
   logic                          valid_ff, valid_in;
   logic                          eff_valid, del, after_del, above, stay;

   always_comb begin
      eff_valid = valid_ff & ~cmd.restart;
      del       = cmd.full & eff_valid & (age_ff == age_last);
      after_del = cmd.full & eff_valid & ~del & (value_ff >= oldest_value);
      above     = eff_valid & (value_ff > sample);
      link.valid = eff_valid;
      // the leaving cell hands nothing on
      link.up    = above & ~after_del & ~del;
      link.down  = after_del & ~above;
      stay       = eff_valid & ~del & ~link.up & ~link.down;

      if (next_link.down) begin
         value_in = next_value;
         age_in   = next_age + AGE_BITS'(1);
      end else if (prev_link.up) begin
         value_in = prev_value;
         age_in   = prev_age + AGE_BITS'(1);
      end else if (stay) begin
         value_in = value_ff;
         age_in   = age_ff + AGE_BITS'(1);
      end else begin
         value_in = sample;
         age_in   = '0;
      end
      valid_in = eff_valid | (~cmd.full & prev_link.valid);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff <= 1'b0;
      end else if (cmd.load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   assign value      = value_ff;
   assign age        = age_ff;
   assign oldest_tap = del ? value_ff : '0;
   assign lo_tap     = (AGE_BITS'(INDEX) == lo_index) ? value_ff : '0;
   assign hi_tap     = (AGE_BITS'(INDEX) == hi_index) ? value_ff : '0;

endmodule

### rtl/core/swm_chain.sv
// ----------------------------------------------------------------------------
// swm_chain
// Row of sorting cells holding the window in ascending order, with the
// oldest-value broadcast and the middle-pair adder.
// ----------------------------------------------------------------------------
module swm_chain
   import swm_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_WINDOW  = 64,
   parameter int AGE_BITS    = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swm_cmd_type                   cmd,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic [AGE_BITS-1:0]           age_last,
   input  logic [AGE_BITS-1:0]           lo_index,
   input  logic [AGE_BITS-1:0]           hi_index,
   output logic signed [SAMPLE_BITS:0]   median_doubled
);

   swm_link_type                  link       [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] cell_value [MAX_WINDOW];
   logic [AGE_BITS-1:0]           cell_age   [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] old_tap    [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] lo_tap     [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] hi_tap     [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] oldest_value, lo_value, hi_value;

   localparam swm_link_type EDGE_HEAD = '{valid: 1'b1, up: 1'b0, down: 1'b0};
   localparam swm_link_type EDGE_TAIL = '{valid: 1'b0, up: 1'b0, down: 1'b0};

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      swm_link_type                  p_link, n_link;
      logic signed [SAMPLE_BITS-1:0] p_value, n_value;
      logic [AGE_BITS-1:0]           p_age, n_age;

      if (i == 0) begin : g_head
         assign p_link  = EDGE_HEAD;
         assign p_value = '0;
         assign p_age   = '0;
      end else begin : g_prev
         assign p_link  = link[i-1];
         assign p_value = cell_value[i-1];
         assign p_age   = cell_age[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_tail
         assign n_link  = EDGE_TAIL;
         assign n_value = '0;
         assign n_age   = '0;
      end else begin : g_next
         assign n_link  = link[i+1];
         assign n_value = cell_value[i+1];
         assign n_age   = cell_age[i+1];
      end

      swm_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .AGE_BITS    (AGE_BITS),
         .INDEX       (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .sample       (sample),
         .oldest_value (oldest_value),
         .age_last     (age_last),
         .lo_index     (lo_index),
         .hi_index     (hi_index),
         .prev_link    (p_link),
         .prev_value   (p_value),
         .prev_age     (p_age),
         .next_link    (n_link),
         .next_value   (n_value),
         .next_age     (n_age),
         .link         (link[i]),
         .value        (cell_value[i]),
         .age          (cell_age[i]),
         .oldest_tap   (old_tap[i]),
         .lo_tap       (lo_tap[i]),
         .hi_tap       (hi_tap[i])
      );
   end

   // one-hot selects, so plain OR reductions
   always_comb begin
      oldest_value = '0;
      lo_value     = '0;
      hi_value     = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         oldest_value = oldest_value | old_tap[i];
         lo_value     = lo_value | lo_tap[i];
         hi_value     = hi_value | hi_tap[i];
      end
   end

   assign median_doubled = {lo_value[SAMPLE_BITS-1], lo_value}
                         + {hi_value[SAMPLE_BITS-1], hi_value};

endmodule

### rtl/core/sliding_window_median.sv
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median filter: twice the median of the last window_size samples.
// ----------------------------------------------------------------------------
// The window is held sorted in a row of MAX_WINDOW cells, each tagged with the
// sample's age; a transaction removes the oldest cell and inserts the new
// sample. A sample that does not complete a window leaves the block ready for
// the next; one that yields a result stalls requests until the two middle cells
// are summed into the output register, which has to be free (or emptied in
// that cycle) before the next sample is taken. No result is given until the
// window first fills. A write with csr_wr_en, or a sample with req_restart
// set, empties the window; window_size 0 acts as 1 and values above
// MAX_WINDOW act as MAX_WINDOW.
module sliding_window_median
   import swm_pkg::*;
#(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS:0]   rsp_median_doubled,
   input  logic                          csr_wr_en,
   input  logic [WINDOW_SIZE_BITS-1:0]   csr_wr_data
);

   localparam int AGE_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
   localparam int KW       = (CNT_BITS > WINDOW_SIZE_BITS) ? CNT_BITS : WINDOW_SIZE_BITS;

   logic [WINDOW_SIZE_BITS-1:0]   csr_window_size_ff;
   logic [CNT_BITS-1:0]           fill_ff, fill_in;
   logic                          pend_ff, pend_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS:0]   rsp_median_ff;
   logic [KW-1:0]                 ws_wide;
   logic [CNT_BITS-1:0]           k_eff, fill_eff, fill_inc;
   logic [AGE_BITS-1:0]           age_last, lo_index, hi_index;
   logic                          accept, full, emit, out_free, out_load;
   logic signed [SAMPLE_BITS:0]   chain_median;
   swm_cmd_type                   cmd;

   always_comb begin
      ws_wide = KW'(csr_window_size_ff);
      if (ws_wide == '0) begin
         k_eff = CNT_BITS'(1);
      end else if (ws_wide > KW'(MAX_WINDOW)) begin
         k_eff = CNT_BITS'(MAX_WINDOW);
      end else begin
         k_eff = CNT_BITS'(ws_wide);
      end
      age_last = AGE_BITS'(k_eff - CNT_BITS'(1));
      lo_index = AGE_BITS'((k_eff - CNT_BITS'(1)) >> 1);
      hi_index = AGE_BITS'(k_eff >> 1);
   end

   assign accept   = req_valid & ~req_stall;
   assign fill_eff = req_restart ? '0 : fill_ff;
   assign full     = (fill_eff == k_eff);
   assign fill_inc = fill_eff + CNT_BITS'(1);
   assign emit     = full | (fill_inc == k_eff);
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign out_load = pend_ff & out_free;

   assign cmd.load    = accept;
   assign cmd.clear   = csr_wr_en;
   assign cmd.full    = full;
   assign cmd.restart = req_restart;

   always_comb begin
      fill_in = fill_ff;
      if (csr_wr_en) begin
         fill_in = '0;
      end else if (accept) begin
         fill_in = full ? fill_eff : fill_inc;
      end

      pend_in = pend_ff;
      if (accept) begin
         pend_in = emit;
      end else if (out_load) begin
         pend_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_window_size_ff <= WINDOW_SIZE_RESET;
         fill_ff            <= '0;
         pend_ff            <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_window_size_ff <= csr_wr_data;
         end
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_median_ff <= chain_median;
      end
   end

   swm_chain #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_WINDOW  (MAX_WINDOW),
      .AGE_BITS    (AGE_BITS)
   ) u_chain (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sample         (req_sample),
      .age_last       (age_last),
      .lo_index       (lo_index),
      .hi_index       (hi_index),
      .median_doubled (chain_median)
   );

   assign req_stall          = pend_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = rsp_median_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= k_eff) else $error("fill count beyond window size");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff && !pend_ff) else $error("pending result not loaded");

   a_no_emit: assert property (@(posedge clock) disable iff (reset)
      accept && !emit |=> !pend_ff) else $error("result raised before window full");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_restart && !csr_wr_en |=> fill_ff == CNT_BITS'(1))
      else $error("restart did not start a new window");
`endif

endmodule
